// ----- hdl/sei_pkg.sv -----
// Shared types, constants and codes of the signed energy integrator.
package sei_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 24;
    localparam int QUEUE_DEPTH_DEF    = 2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_OFFSET = 2'd1;

    localparam logic [31:0] POWER_GAIN_RESET = 32'd1634462;
    localparam logic [62:0] TOTAL_MAX        = {63{1'b1}};

    // Scaled power sample handed from front to back.
    typedef struct packed {
        logic signed [31:0] power_mw;
        logic [31:0]        timestamp_ms;
    } t_mid_item;

    // One result transaction.
    typedef struct packed {
        logic signed [31:0] power_mw;
        logic [62:0]        received_total;
        logic [62:0]        exported_total;
        logic               integrated;
    } t_result;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL,
        FR_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SUM,
        BK_MUL,
        BK_ACC
    } t_back_state;

endpackage

// ----- hdl/sei_fifo.sv -----
// Small register queue between pipeline parts.
module sei_fifo import sei_pkg::*; #(
    parameter int W     = 64,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_wr, w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_wr) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_rd) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        case ({w_wr, w_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- hdl/sei_front.sv -----
// Front end: takes a raw sample, scales it to mW, adds the offset and saturates it.
module sei_front import sei_pkg::*; #(
    parameter int GAIN_FRACTION_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic signed [31:0] i_raw_power,
    input  logic [31:0]        i_timestamp_ms,
    input  logic [31:0]        i_power_gain,
    input  logic signed [31:0] i_power_offset_mw,
    output t_mid_item          o_item,
    output logic               o_item_push,
    input  logic               i_item_full
);

    localparam logic signed [65:0] P_MAX = 66'sh7FFFFFFF;
    localparam logic signed [65:0] P_MIN = -P_MAX - 66'sd1;

    t_front_state r_state, n_state;

    logic signed [31:0] r_raw;
    logic [31:0]        r_ts;
    logic signed [64:0] r_prod;

    logic signed [32:0] w_raw_s;
    logic signed [32:0] w_gain_s;
    logic signed [64:0] w_prod;
    logic signed [64:0] w_shift;
    logic signed [65:0] w_sum;
    logic signed [31:0] w_power;
    logic               w_load;

    assign w_raw_s  = {r_raw[31], r_raw};
    assign w_gain_s = {1'b0, i_power_gain};
    assign w_prod   = w_raw_s * w_gain_s;

    // Arithmetic shift floors toward minus infinity, as the scaling requires.
    assign w_shift = r_prod >>> GAIN_FRACTION_BITS;
    assign w_sum   = {w_shift[64], w_shift} + {{34{i_power_offset_mw[31]}}, i_power_offset_mw};

    always_comb begin
        if (w_sum > P_MAX) begin
            w_power = 32'sh7FFFFFFF;
        end else if (w_sum < P_MIN) begin
            w_power = 32'sh80000000;
        end else begin
            w_power = w_sum[31:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_IDLE: begin
                if (i_push) begin
                    n_state = FR_MUL;
                end
            end
            FR_MUL:  n_state = FR_PUSH;
            FR_PUSH: begin
                if (!i_item_full) begin
                    n_state = FR_IDLE;
                end
            end
            default: n_state = FR_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_full      = 1'b1;
        w_load      = 1'b0;
        o_item_push = 1'b0;
        case (r_state)
            FR_IDLE: begin
                o_full = 1'b0;
                w_load = i_push;
            end
            FR_PUSH: o_item_push = !i_item_full;
            default: ;
        endcase
    end

    assign o_item.power_mw     = w_power;
    assign o_item.timestamp_ms = r_ts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_raw <= i_raw_power;
            r_ts  <= i_timestamp_ms;
        end
        if (r_state == FR_MUL) begin
            r_prod <= w_prod;
        end
    end

endmodule

// ----- hdl/sei_back.sv -----
// Back end: trapezoid integration into saturating import/export totals.
module sei_back import sei_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mid_item i_item,
    input  logic      i_item_empty,
    output logic      o_item_pop,
    output t_result   o_res,
    output logic      o_res_push,
    input  logic      i_res_full
);

    t_back_state r_state, n_state;

    logic signed [31:0] r_cur_power;
    logic [31:0]        r_cur_ts;
    logic signed [31:0] r_prev_power;
    logic [31:0]        r_prev_time;
    logic               r_have_prev;
    logic [62:0]        r_import_sum;
    logic [62:0]        r_export_sum;
    logic [32:0]        r_mag;
    logic [31:0]        r_elapsed;
    logic               r_is_import;
    logic [64:0]        r_energy;

    logic signed [32:0] w_psum;
    logic signed [33:0] w_pneg;
    logic [65:0]        w_imp_add;
    logic [65:0]        w_exp_add;
    logic [62:0]        n_import_sum;
    logic [62:0]        n_export_sum;

    // Sum of neighboring samples; zero counts as export.
    assign w_psum = {r_prev_power[31], r_prev_power} + {r_cur_power[31], r_cur_power};
    assign w_pneg = -{w_psum[32], w_psum};

    assign w_imp_add = {3'b0, r_import_sum} + {1'b0, r_energy};
    assign w_exp_add = {3'b0, r_export_sum} + {1'b0, r_energy};

    always_comb begin
        n_import_sum = r_import_sum;
        n_export_sum = r_export_sum;
        if (r_have_prev) begin
            if (r_is_import) begin
                n_import_sum = (w_imp_add > {3'b0, TOTAL_MAX}) ? TOTAL_MAX : w_imp_add[62:0];
            end else begin
                n_export_sum = (w_exp_add > {3'b0, TOTAL_MAX}) ? TOTAL_MAX : w_exp_add[62:0];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_item_empty) begin
                    n_state = BK_SUM;
                end
            end
            BK_SUM: n_state = BK_MUL;
            BK_MUL: n_state = BK_ACC;
            BK_ACC: begin
                if (!i_res_full) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            BK_IDLE: o_item_pop = !i_item_empty;
            BK_ACC:  o_res_push = !i_res_full;
            default: ;
        endcase
    end

    assign o_res.power_mw       = r_cur_power;
    assign o_res.received_total = n_import_sum;
    assign o_res.exported_total = n_export_sum;
    assign o_res.integrated     = r_have_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_have_prev  <= 1'b0;
            r_prev_power <= '0;
            r_prev_time  <= '0;
            r_import_sum <= '0;
            r_export_sum <= '0;
        end else begin
            r_state <= n_state;
            if (o_res_push) begin
                r_have_prev  <= 1'b1;
                r_prev_power <= r_cur_power;
                r_prev_time  <= r_cur_ts;
                r_import_sum <= n_import_sum;
                r_export_sum <= n_export_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_cur_power <= i_item.power_mw;
            r_cur_ts    <= i_item.timestamp_ms;
        end
        if (r_state == BK_SUM) begin
            r_mag       <= w_psum[32] ? w_pneg[32:0] : w_psum;
            r_is_import <= (w_psum > 33'sd0);
            r_elapsed   <= r_cur_ts - r_prev_time;  // wraps modulo 2^32
        end
        if (r_state == BK_MUL) begin
            r_energy <= r_mag * r_elapsed;
        end
    end

endmodule

// ----- hdl/signed_energy_integrator_top.sv -----
// Top level of the signed energy integrator.
//
// Each accepted transaction carries a signed raw active-power reading and a
// millisecond timestamp and yields exactly one result transaction: the power
// in mW, floor(raw * power_gain / 2^GAIN_FRACTION_BITS) + power_offset_mw
// saturated to 32 bits, plus the imported and exported energy totals in
// half mW*ms (trapezoid rule, elapsed time modulo 2^32, totals saturate at
// 2^63-1). The first sample after reset only seeds the state and reports
// integrated = 0. For each sample the front end steps through capture, 33x33
// multiply and shift/offset/saturate; the back end steps through pop, power sum
// and elapsed time, 33x32 multiply and saturating accumulate. The back-end
// sequencer takes a new sample only after its accumulate step, so it sets the
// sustained rate. Two-entry queues sit between the parts and in front of the
// result ports, so input and output stall independently. Config writes are
// always taken (cfg_ready is tied high) and must only happen while no sample is
// in flight; indexes past the register list are ignored.
module signed_energy_integrator_top import sei_pkg::*; #(
    parameter int GAIN_FRACTION_BITS = GAIN_FRAC_BITS_DEF,
    parameter int MID_DEPTH          = QUEUE_DEPTH_DEF,
    parameter int OUT_DEPTH          = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // sample input
    input  logic                 push,
    output logic                 full,
    input  logic signed [31:0]   i_raw_power,
    input  logic [31:0]          i_timestamp_ms,
    // results
    output logic                 empty,
    input  logic                 pop,
    output logic signed [31:0]   o_power_mw,
    output logic [62:0]          o_received_total,
    output logic [62:0]          o_exported_total,
    output logic                 o_integrated,
    // config writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    logic [31:0]        r_power_gain;
    logic signed [31:0] r_power_offset_mw;

    t_mid_item w_fr_item;
    t_mid_item w_bk_item;
    logic      w_fr_push, w_mid_full, w_mid_empty, w_bk_pop;
    t_result   w_bk_res;
    t_result   w_out_res;
    logic      w_res_push, w_res_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_gain      <= POWER_GAIN_RESET;
            r_power_offset_mw <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_POWER_GAIN:   r_power_gain      <= i_cfg_data;
                CFG_POWER_OFFSET: r_power_offset_mw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sei_front #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_raw_power      (i_raw_power),
        .i_timestamp_ms   (i_timestamp_ms),
        .i_power_gain     (r_power_gain),
        .i_power_offset_mw(r_power_offset_mw),
        .o_item           (w_fr_item),
        .o_item_push      (w_fr_push),
        .i_item_full      (w_mid_full)
    );

    sei_fifo #(
        .W    ($bits(t_mid_item)),
        .DEPTH(MID_DEPTH)
    ) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_fr_push),
        .i_data (w_fr_item),
        .o_full (w_mid_full),
        .i_pop  (w_bk_pop),
        .o_data (w_bk_item),
        .o_empty(w_mid_empty)
    );

    sei_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_bk_item),
        .i_item_empty(w_mid_empty),
        .o_item_pop  (w_bk_pop),
        .o_res       (w_bk_res),
        .o_res_push  (w_res_push),
        .i_res_full  (w_res_full)
    );

    sei_fifo #(
        .W    ($bits(t_result)),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_bk_res),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_data (w_out_res),
        .o_empty(empty)
    );

    assign o_power_mw       = w_out_res.power_mw;
    assign o_received_total = w_out_res.received_total;
    assign o_exported_total = w_out_res.exported_total;
    assign o_integrated     = w_out_res.integrated;

endmodule

// ----- hdl/sei_checker.sv -----
// Port-level checker for the signed energy integrator, bound to the top.
module sei_checker import sei_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 full,
    input logic                 empty,
    input logic                 pop,
    input logic signed [31:0]   o_power_mw,
    input logic [62:0]          o_received_total,
    input logic [62:0]          o_exported_total,
    input logic                 o_integrated
);

    logic        r_seen;
    logic [62:0] r_last_rx;
    logic [62:0] r_last_tx;
    logic        w_take;

    assign w_take = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (w_take) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_last_rx <= o_received_total;
            r_last_tx <= o_exported_total;
        end
    end

    // reset leaves no result pending and the input open
    a_reset_clean: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queue state not clean after reset");

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_power_mw) && $stable(o_received_total)
                              && $stable(o_exported_total) && $stable(o_integrated)))
        else $error("pending result changed before pop");

    // only the first result after reset seeds
    a_integrate_after_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_seen) |-> o_integrated)
        else $error("later result did not integrate");

    // totals never go down between consecutive results
    a_rx_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_seen) |-> (o_received_total >= r_last_rx))
        else $error("received total decreased");

    a_tx_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_seen) |-> (o_exported_total >= r_last_tx))
        else $error("exported total decreased");

endmodule

bind signed_energy_integrator_top sei_checker u_sei_checker (.*);
